[design/assert_macros.svh]
// Assertion macros used by the top level of the word cipher.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[design/smc_pkg.sv]
// Package of the word cipher: codes, constants, pipeline types and helpers.
// Depends on nothing; used by the top level and the testbench.
`default_nettype none

package smc_pkg;

    typedef enum logic [1:0] {
        ACT_ENCRYPT   = 2'd0,
        ACT_DECRYPT   = 2'd1,
        ACT_KEYSTREAM = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        WS_8  = 2'd0,
        WS_16 = 2'd1,
        WS_32 = 2'd2,
        WS_64 = 2'd3
    } word_size_t;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 64;
    localparam int unsigned NUM_STAGES = 7;

    localparam logic NONCE_SEL = 1'b0;
    localparam logic KEY_SEL   = 1'b1;

    localparam logic [63:0] NONCE_ADD = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] KEY_MUL   = 64'h6C62272E07BB0142;
    localparam logic [63:0] BLK_MUL   = 64'h517CC1B727220A95;
    localparam logic [63:0] FIN_MUL1  = 64'hFF51AFD7ED558CCD;
    localparam logic [63:0] FIN_MUL2  = 64'hC4CEB9FE1A85EC53;

    localparam logic [7:0]  WKEY_8  = 8'hB7;
    localparam logic [15:0] WKEY_16 = 16'hA3C5;
    localparam logic [31:0] WKEY_32 = 32'h9E3779B1;
    localparam logic [63:0] WKEY_64 = 64'h9E3779B19E3779B1;

    localparam int unsigned ROT_NARROW = 5;
    localparam int unsigned ROT_WIDE   = 13;
    localparam int unsigned FIN_SHIFT  = 33;

    typedef struct packed {
        logic [1:0]  act;
        logic [1:0]  ws;
        logic [63:0] data;
    } side_t;

    function automatic logic [63:0] mul_full(input logic [31:0] a, input logic [31:0] b);
        return {32'b0, a} * {32'b0, b};
    endfunction

    function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
        return a * b;
    endfunction

    function automatic logic [63:0] mul_join(input logic [63:0] ll, input logic [31:0] lh,
                                             input logic [31:0] hl);
        logic [31:0] mid_sum;
        mid_sum = lh + hl;
        return ll + {mid_sum, 32'b0};
    endfunction

    function automatic logic [63:0] xor_shift(input logic [63:0] x);
        return x ^ (x >> FIN_SHIFT);
    endfunction

    function automatic logic [63:0] cipher_word(input logic [1:0] act, input logic [1:0] ws,
                                                input logic [63:0] data,
                                                input logic [63:0] ks);
        logic [7:0]  v8, u8, e8, d8;
        logic [15:0] v16, u16, e16, d16;
        logic [31:0] v32, u32, e32, d32;
        logic [63:0] v64, u64, e64, d64;
        logic [63:0] enc, dec;
        v8  = data[7:0] ^ ks[7:0];
        v16 = data[15:0] ^ ks[15:0];
        v32 = data[31:0] ^ ks[31:0];
        v64 = data ^ ks;
        e8  = 8'((v8 << ROT_NARROW) | (v8 >> (8 - ROT_NARROW))) ^ WKEY_8;
        e16 = 16'((v16 << ROT_WIDE) | (v16 >> (16 - ROT_WIDE))) ^ WKEY_16;
        e32 = 32'((v32 << ROT_WIDE) | (v32 >> (32 - ROT_WIDE))) ^ WKEY_32;
        e64 = 64'((v64 << ROT_WIDE) | (v64 >> (64 - ROT_WIDE))) ^ WKEY_64;
        u8  = data[7:0] ^ WKEY_8;
        u16 = data[15:0] ^ WKEY_16;
        u32 = data[31:0] ^ WKEY_32;
        u64 = data ^ WKEY_64;
        d8  = 8'((u8 >> ROT_NARROW) | (u8 << (8 - ROT_NARROW))) ^ ks[7:0];
        d16 = 16'((u16 >> ROT_WIDE) | (u16 << (16 - ROT_WIDE))) ^ ks[15:0];
        d32 = 32'((u32 >> ROT_WIDE) | (u32 << (32 - ROT_WIDE))) ^ ks[31:0];
        d64 = 64'((u64 >> ROT_WIDE) | (u64 << (64 - ROT_WIDE))) ^ ks;
        case (word_size_t'(ws))
            WS_8:
            begin
                enc = {56'b0, e8};
                dec = {56'b0, d8};
            end
            WS_16:
            begin
                enc = {48'b0, e16};
                dec = {48'b0, d16};
            end
            WS_32:
            begin
                enc = {32'b0, e32};
                dec = {32'b0, d32};
            end
            default:
            begin
                enc = e64;
                dec = d64;
            end
        endcase
        case (action_t'(act))
            ACT_ENCRYPT:   return enc;
            ACT_DECRYPT:   return dec;
            ACT_KEYSTREAM: return {32'b0, ks[31:0]};
            default:       return 64'b0;
        endcase
    endfunction

endpackage

`default_nettype wire

[design/smc_in_if.sv]
// Input channel of the word cipher: valid/ready handshake with one request item.
// Depends on nothing.
`default_nettype none

interface smc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [1:0]  word_size;
    logic [63:0] data_word;
    logic [31:0] block_number;

    modport source (output valid, output action, output word_size, output data_word,
                    output block_number, input ready);
    modport sink (input valid, input action, input word_size, input data_word,
                  input block_number, output ready);
endinterface

`default_nettype wire

[design/smc_out_if.sv]
// Output channel of the word cipher: valid/ready handshake with one result item.
// Depends on nothing.
`default_nettype none

interface smc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_word;

    modport source (output valid, output result_word, input ready);
    modport sink (input valid, input result_word, output ready);
endinterface

`default_nettype wire

[design/splitmix_ctr_word_cipher.sv]
// Top level of the counter-mode word cipher with its APB register port.
// Depends on smc_pkg, smc_in_if, smc_out_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// The block takes one item per clock unless the output stalls, and its result leaves from the
// register of the last stage. Each 64-bit multiply of the keystream is split into 32-bit partial
// products in one stage and summed in the next, which sets the seven-stage depth. Every stage
// has its own valid bit, so bubbles close up while the output is stalled and the input keeps
// accepting until the pipeline is full. The nonce sits at byte address 0 and the key seed at
// byte address 8; write them only while no item is in flight.
module splitmix_ctr_word_cipher (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [smc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [smc_pkg::PDATA_W-1:0] pwdata,
    output logic      [smc_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    smc_in_if.sink                           req,
    smc_out_if.source                        rsp
);

    localparam int unsigned NS = smc_pkg::NUM_STAGES;

    logic [63:0] nonce_reg;
    logic [31:0] key_reg;
    logic        cfg_write;

    logic [NS:1] valid_reg;
    logic [NS:1] en;
    smc_pkg::side_t side_reg [1:NS];
    smc_pkg::side_t side_next;

    logic [31:0] blk;
    logic [63:0] s1_nsum_reg, s1_nsum_next;
    logic [63:0] s1_kp_lo_reg, s1_kp_lo_next;
    logic [31:0] s1_kp_hi_reg, s1_kp_hi_next;
    logic [63:0] s1_bp_lo_reg, s1_bp_lo_next;
    logic [31:0] s1_bp_hi_reg, s1_bp_hi_next;
    logic [63:0] s2_x_reg, s2_x_next;
    logic [63:0] s3_ll_reg, s3_ll_next;
    logic [31:0] s3_lh_reg, s3_lh_next;
    logic [31:0] s3_hl_reg, s3_hl_next;
    logic [63:0] s4_y_reg, s4_y_next;
    logic [63:0] s5_ll_reg, s5_ll_next;
    logic [31:0] s5_lh_reg, s5_lh_next;
    logic [31:0] s5_hl_reg, s5_hl_next;
    logic [63:0] s6_ks_reg, s6_ks_next;
    logic [63:0] out_reg, out_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[3] == smc_pkg::KEY_SEL) ? {32'b0, key_reg} : nonce_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonce_reg <= '0;
            key_reg   <= '0;
        end
        else if (cfg_write)
        begin
            if (paddr[3] == smc_pkg::KEY_SEL)
            begin
                key_reg <= pwdata[31:0];
            end
            else
            begin
                nonce_reg <= pwdata;
            end
        end
    end

    always_comb
    begin
        en[NS] = !valid_reg[NS] || rsp.ready;
        for (int k = NS - 1; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || en[k + 1];
        end
    end

    assign req.ready = en[1];
    assign rsp.valid = valid_reg[NS];
    assign rsp.result_word = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                valid_reg[1] <= req.valid;
            end
            for (int k = 2; k <= NS; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k - 1];
                end
            end
        end
    end

    always_comb
    begin
        side_next.act  = req.action;
        side_next.ws   = req.word_size;
        side_next.data = req.data_word;
        blk = (req.action == smc_pkg::ACT_KEYSTREAM) ? 32'b0 : req.block_number;
        s1_nsum_next  = nonce_reg + smc_pkg::NONCE_ADD;
        s1_kp_lo_next = smc_pkg::mul_full(key_reg, smc_pkg::KEY_MUL[31:0]);
        s1_kp_hi_next = smc_pkg::mul_lo(key_reg, smc_pkg::KEY_MUL[63:32]);
        s1_bp_lo_next = smc_pkg::mul_full(blk, smc_pkg::BLK_MUL[31:0]);
        s1_bp_hi_next = smc_pkg::mul_lo(blk, smc_pkg::BLK_MUL[63:32]);
        s2_x_next = smc_pkg::xor_shift(s1_nsum_reg
                                       ^ (s1_kp_lo_reg + {s1_kp_hi_reg, 32'b0})
                                       ^ (s1_bp_lo_reg + {s1_bp_hi_reg, 32'b0}));
        s3_ll_next = smc_pkg::mul_full(s2_x_reg[31:0], smc_pkg::FIN_MUL1[31:0]);
        s3_lh_next = smc_pkg::mul_lo(s2_x_reg[31:0], smc_pkg::FIN_MUL1[63:32]);
        s3_hl_next = smc_pkg::mul_lo(s2_x_reg[63:32], smc_pkg::FIN_MUL1[31:0]);
        s4_y_next  = smc_pkg::xor_shift(smc_pkg::mul_join(s3_ll_reg, s3_lh_reg, s3_hl_reg));
        s5_ll_next = smc_pkg::mul_full(s4_y_reg[31:0], smc_pkg::FIN_MUL2[31:0]);
        s5_lh_next = smc_pkg::mul_lo(s4_y_reg[31:0], smc_pkg::FIN_MUL2[63:32]);
        s5_hl_next = smc_pkg::mul_lo(s4_y_reg[63:32], smc_pkg::FIN_MUL2[31:0]);
        s6_ks_next = smc_pkg::xor_shift(smc_pkg::mul_join(s5_ll_reg, s5_lh_reg, s5_hl_reg));
        out_next = smc_pkg::cipher_word(side_reg[NS - 1].act, side_reg[NS - 1].ws,
                                        side_reg[NS - 1].data, s6_ks_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            side_reg[1]  <= side_next;
            s1_nsum_reg  <= s1_nsum_next;
            s1_kp_lo_reg <= s1_kp_lo_next;
            s1_kp_hi_reg <= s1_kp_hi_next;
            s1_bp_lo_reg <= s1_bp_lo_next;
            s1_bp_hi_reg <= s1_bp_hi_next;
        end
        for (int k = 2; k <= NS; k++)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_reg[k - 1];
            end
        end
        if (en[2])
        begin
            s2_x_reg <= s2_x_next;
        end
        if (en[3])
        begin
            s3_ll_reg <= s3_ll_next;
            s3_lh_reg <= s3_lh_next;
            s3_hl_reg <= s3_hl_next;
        end
        if (en[4])
        begin
            s4_y_reg <= s4_y_next;
        end
        if (en[5])
        begin
            s5_ll_reg <= s5_ll_next;
            s5_lh_reg <= s5_lh_next;
            s5_hl_reg <= s5_hl_next;
        end
        if (en[6])
        begin
            s6_ks_reg <= s6_ks_next;
        end
        if (en[7])
        begin
            out_reg <= out_next;
        end
    end

    `ASSERT_NEXT(a_accept_fills_first, clk, rst_n, req.valid && req.ready, valid_reg[1])
    `ASSERT_SAME(a_keystream_upper_zero, clk, rst_n,
                 rsp.valid && (side_reg[NS].act == smc_pkg::ACT_KEYSTREAM),
                 rsp.result_word[63:32] == 32'b0)
    `ASSERT_SAME(a_byte_zero_extended, clk, rst_n,
                 rsp.valid && (side_reg[NS].ws == smc_pkg::WS_8)
                 && (side_reg[NS].act != smc_pkg::ACT_KEYSTREAM),
                 rsp.result_word[63:8] == 56'b0)
    `ASSERT_NEXT(a_stall_keeps_item, clk, rst_n, rsp.valid && !rsp.ready, valid_reg[NS])

endmodule

`default_nettype wire

[verif/splitmix_ctr_word_cipher_test.sv]
// Self-checking testbench of the counter-mode word cipher: random and directed items
// with random idling on both channels, checked against an in-bench predictor.
// Depends on smc_pkg, smc_in_if, smc_out_if and the splitmix_ctr_word_cipher top level.
`default_nettype none

module splitmix_ctr_word_cipher_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [smc_pkg::PADDR_W-1:0] ADDR_NONCE = smc_pkg::PADDR_W'(0);
    localparam logic [smc_pkg::PADDR_W-1:0] ADDR_KEY   = smc_pkg::PADDR_W'(8);
    localparam logic [1:0]         ACT_UNUSED = 2'd3;
    localparam int unsigned        CYCLE_LIMIT = 400000;
    localparam int unsigned        LONG_HOLD = 300;
    localparam int unsigned        DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  word_size;
        logic [63:0] data_word;
        logic [31:0] block_number;
    } cipher_item_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [smc_pkg::PADDR_W-1:0]  paddr;
    logic [smc_pkg::PDATA_W-1:0]  pwdata;
    wire  [smc_pkg::PDATA_W-1:0]  prdata;
    wire                          pready;

    smc_in_if  req_ch ();
    smc_out_if rsp_ch ();

    splitmix_ctr_word_cipher i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    cipher_item_t pending_items[$];
    logic [63:0]  expected_words[$];
    logic [63:0]  nonce_cfg;
    logic [31:0]  key_cfg;
    int unsigned  in_idle_pct;
    int unsigned  out_idle_pct;
    int unsigned  gap_left;
    int unsigned  hold_left;
    int unsigned  results_seen;
    int unsigned  error_count;
    int unsigned  cycle_count;
    logic         long_start;
    logic [63:0]  head_word;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [63:0] keystream_word(input logic [31:0] blk);
        logic [63:0] x;
        x = (nonce_cfg + 64'h9E3779B97F4A7C15)
            ^ ({32'b0, key_cfg} * 64'h6C62272E07BB0142)
            ^ ({32'b0, blk} * 64'h517CC1B727220A95);
        x = x ^ (x >> 33);
        x = x * 64'hFF51AFD7ED558CCD;
        x = x ^ (x >> 33);
        x = x * 64'hC4CEB9FE1A85EC53;
        x = x ^ (x >> 33);
        return x;
    endfunction

    function automatic logic [63:0] cipher_expect(input logic [1:0] act, input logic [1:0] ws,
                                                  input logic [63:0] data,
                                                  input logic [31:0] blk);
        int unsigned bits;
        int unsigned sh;
        logic [63:0] m;
        logic [63:0] wkey;
        logic [63:0] ks;
        logic [63:0] v;
        logic [63:0] r;
        case (smc_pkg::word_size_t'(ws))
            smc_pkg::WS_8:
            begin
                bits = 8;
                wkey = 64'hB7;
            end
            smc_pkg::WS_16:
            begin
                bits = 16;
                wkey = 64'hA3C5;
            end
            smc_pkg::WS_32:
            begin
                bits = 32;
                wkey = 64'h9E3779B1;
            end
            default:
            begin
                bits = 64;
                wkey = 64'h9E3779B19E3779B1;
            end
        endcase
        m = (bits == 64) ? {64{1'b1}} : ((64'd1 << bits) - 64'd1);
        sh = (bits == 8) ? 5 : 13;
        case (act)
            smc_pkg::ACT_ENCRYPT:
            begin
                ks = keystream_word(blk) & m;
                v = (data & m) ^ ks;
                r = (((v << sh) | (v >> (bits - sh))) & m) ^ wkey;
                r = r & m;
            end
            smc_pkg::ACT_DECRYPT:
            begin
                ks = keystream_word(blk) & m;
                v = (data & m) ^ wkey;
                r = (((v >> sh) | (v << (bits - sh))) & m) ^ ks;
                r = r & m;
            end
            smc_pkg::ACT_KEYSTREAM:
            begin
                ks = keystream_word(32'd0);
                r = {32'b0, ks[31:0]};
            end
            default:
            begin
                r = 64'd0;
            end
        endcase
        return r;
    endfunction

    function automatic cipher_item_t draw_item();
        cipher_item_t it;
        int unsigned  sel;
        sel = $urandom_range(99);
        if (sel < 44)
            it.action = smc_pkg::ACT_ENCRYPT;
        else if (sel < 88)
            it.action = smc_pkg::ACT_DECRYPT;
        else if (sel < 96)
            it.action = smc_pkg::ACT_KEYSTREAM;
        else
            it.action = ACT_UNUSED;
        it.word_size = 2'($urandom_range(3));
        it.data_word = {$urandom, $urandom};
        if ($urandom_range(9) == 0)
            it.data_word = ($urandom_range(1) == 0) ? 64'd0 : {64{1'b1}};
        it.block_number = $urandom;
        if ($urandom_range(3) == 0)
            it.block_number = 32'($urandom_range(15));
        return it;
    endfunction

    task automatic add_item(input logic [1:0] act, input logic [1:0] ws,
                            input logic [63:0] data, input logic [31:0] blk);
        pending_items.push_back({act, ws, data, blk});
    endtask

    task automatic add_random(input int unsigned count);
        repeat (count)
            pending_items.push_back(draw_item());
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || req_ch.valid || expected_words.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic reg_write(input logic [smc_pkg::PADDR_W-1:0] addr,
                             input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic new_setting(input logic [63:0] nonce, input logic [31:0] key);
        wait_idle();
        reg_write(ADDR_NONCE, nonce);
        reg_write(ADDR_KEY, {32'b0, key});
        nonce_cfg = nonce;
        key_cfg = key;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_words.push_back(cipher_expect(req_ch.action, req_ch.word_size,
                                                       req_ch.data_word,
                                                       req_ch.block_number));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    {req_ch.action, req_ch.word_size, req_ch.data_word, req_ch.block_number}
                        <= pending_items.pop_front();
                    req_ch.valid <= 1'b1;
                    if ($urandom_range(99) < in_idle_pct)
                        gap_left <= $urandom_range(1, 16);
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            long_start = 1'b0;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen = results_seen + 1;
                if (results_seen == 450 || results_seen == 1500)
                    long_start = 1'b1;
                if (expected_words.size() == 0)
                begin
                    $display("%0t: result item with none expected, expected none, actual %h",
                             $time, rsp_ch.result_word);
                    error_count = error_count + 1;
                end
                else
                begin
                    head_word = expected_words.pop_front();
                    if (rsp_ch.result_word !== head_word)
                    begin
                        $display("%0t: result_word mismatch, expected %h, actual %h",
                                 $time, head_word, rsp_ch.result_word);
                        error_count = error_count + 1;
                    end
                end
            end
            if (long_start)
            begin
                hold_left <= LONG_HOLD;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if ($urandom_range(99) < out_idle_pct)
            begin
                hold_left <= $urandom_range(0, 15);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("splitmix_ctr_word_cipher_test: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.action = smc_pkg::ACT_ENCRYPT;
        req_ch.word_size = smc_pkg::WS_8;
        req_ch.data_word = 64'd0;
        req_ch.block_number = 32'd0;
        rsp_ch.ready = 1'b0;
        nonce_cfg = 64'd0;
        key_cfg = 32'd0;
        in_idle_pct = 0;
        out_idle_pct = 0;
        results_seen = 0;
        error_count = 0;
        cycle_count = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int ws = 0; ws < 4; ws++)
        begin
            add_item(smc_pkg::ACT_ENCRYPT, 2'(ws), 64'd0, 32'd0);
            add_item(smc_pkg::ACT_ENCRYPT, 2'(ws), {64{1'b1}}, {32{1'b1}});
            add_item(smc_pkg::ACT_DECRYPT, 2'(ws), {64{1'b1}}, 32'd0);
            add_item(smc_pkg::ACT_DECRYPT, 2'(ws), 64'd0, {32{1'b1}});
        end
        add_item(smc_pkg::ACT_KEYSTREAM, smc_pkg::WS_64, {64{1'b1}}, {32{1'b1}});
        add_item(smc_pkg::ACT_KEYSTREAM, smc_pkg::WS_8, 64'd0, 32'd0);
        add_item(ACT_UNUSED, smc_pkg::WS_64, {64{1'b1}}, {32{1'b1}});
        add_item(ACT_UNUSED, smc_pkg::WS_8, 64'h0123456789ABCDEF, 32'd5);

        in_idle_pct = 20;
        out_idle_pct = 20;
        add_random(300);

        new_setting({64{1'b1}}, {32{1'b1}});
        in_idle_pct = 10;
        out_idle_pct = 30;
        add_random(300);

        new_setting({$urandom, $urandom}, $urandom);
        in_idle_pct = 35;
        out_idle_pct = 10;
        add_random(400);

        new_setting(64'd0, {32{1'b1}});
        in_idle_pct = 0;
        out_idle_pct = 0;
        add_random(300);

        new_setting({$urandom, $urandom}, $urandom);
        in_idle_pct = 25;
        out_idle_pct = 25;
        add_random(400);
        wait_idle();
        in_idle_pct = 0;
        out_idle_pct = 0;
        add_random(200);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
        begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, expected_words.size());
            error_count = error_count + 1;
        end
        if (error_count == 0)
            $display("splitmix_ctr_word_cipher_test: clean");
        else
            $display("splitmix_ctr_word_cipher_test: errors");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+design
design/smc_pkg.sv
design/smc_in_if.sv
design/smc_out_if.sv
design/splitmix_ctr_word_cipher.sv
verif/splitmix_ctr_word_cipher_test.sv
